>>> rtl/bdpm_pkg.sv
package bdpm_pkg;

	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int FIELD_WIDTH = 32;
	localparam int BIAS_WIDTH = 32;
	localparam int ACC_WIDTH = 64;
	localparam int MOD_WIDTH = 63;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH = 64;
	localparam int CNT_WIDTH = $clog2(ACC_WIDTH);

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIAS = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = 8'd1;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic take;
		logic load_div;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} status_t;

endpackage

>>> rtl/bdpm_datapath.sv
module bdpm_datapath #(
	parameter int ELEMENT_WIDTH = bdpm_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bdpm_pkg::cmd_t                         cmd,
	output bdpm_pkg::status_t                      status,
	input  logic [bdpm_pkg::FIELD_WIDTH-1:0]       lhs_elem,
	input  logic [bdpm_pkg::FIELD_WIDTH-1:0]       rhs_elem,
	input  logic                                   element_present,
	input  logic                                   cfg_valid,
	input  logic [bdpm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [bdpm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	output logic [bdpm_pkg::ACC_WIDTH-1:0]         remainder,
	output logic                                   error
);

	localparam int AW = bdpm_pkg::ACC_WIDTH;
	localparam int MW = bdpm_pkg::MOD_WIDTH;
	localparam int SUM_WIDTH = bdpm_pkg::BIAS_WIDTH + 1;

	logic signed [bdpm_pkg::BIAS_WIDTH-1:0] bias_q;
	logic [MW-1:0]                          mod_q;

	logic signed [ELEMENT_WIDTH-1:0] l_el;
	logic signed [ELEMENT_WIDTH-1:0] r_el;
	logic signed [SUM_WIDTH-1:0]     sum_s1;
	logic signed [ELEMENT_WIDTH-1:0] r_s1;
	logic                            vld_s1;
	logic signed [AW:0]              prod_full;
	logic [AW-1:0]                   prod_s2;
	logic                            vld_s2;
	logic [AW-1:0]                   acc_q;

	logic          neg_q;
	logic [AW-1:0] dvd_q;
	logic [AW-1:0] rem_q;
	logic [AW-1:0] trial;
	logic [AW-1:0] rem_signed;

	logic [AW-1:0] rem_out_q;
	logic          err_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			mod_q  <= MW'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bdpm_pkg::REG_BIAS:    bias_q <= cfg_data[bdpm_pkg::BIAS_WIDTH-1:0];
				bdpm_pkg::REG_MODULUS: mod_q  <= cfg_data[MW-1:0];
				default: ;
			endcase
		end
	end

	assign l_el = lhs_elem[ELEMENT_WIDTH-1:0];
	assign r_el = rhs_elem[ELEMENT_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.take & element_present;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sum_s1 <= SUM_WIDTH'(l_el) + SUM_WIDTH'(bias_q);
			r_s1   <= r_el;
		end
		prod_s2 <= prod_full[AW-1:0];
	end

	assign prod_full = sum_s1 * r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.load_div) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign status.pipe_busy = vld_s1 | vld_s2;

	assign trial = {rem_q[AW-2:0], dvd_q[AW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			neg_q <= acc_q[AW-1];
			dvd_q <= acc_q[AW-1] ? (AW'(0) - acc_q) : acc_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[AW-2:0], 1'b0};
			if (trial >= {1'b0, mod_q}) begin
				rem_q <= trial - {1'b0, mod_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rem_signed = neg_q ? (AW'(0) - rem_q) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			err_out_q <= (mod_q == '0);
			rem_out_q <= (mod_q == '0) ? '0 : rem_signed;
		end
	end

	assign remainder = rem_out_q;
	assign error     = err_out_q;

endmodule

>>> rtl/bdpm_ctrl.sv
module bdpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bdpm_pkg::status_t status,
	output bdpm_pkg::cmd_t    cmd
);

	bdpm_pkg::state_t state_q;
	bdpm_pkg::state_t state_d;

	logic [bdpm_pkg::CNT_WIDTH-1:0] cnt_q;
	logic                           out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdpm_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			bdpm_pkg::ST_ACCUM: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					state_d = bdpm_pkg::ST_DRAIN;
				end
			end
			bdpm_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.load_div = 1'b1;
					state_d      = bdpm_pkg::ST_DIVIDE;
				end
			end
			bdpm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '1) begin
					state_d = bdpm_pkg::ST_HOLD;
				end
			end
			bdpm_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = bdpm_pkg::ST_ACCUM;
				end
			end
			default: state_d = bdpm_pkg::ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_div) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/biased_dot_product_mod.sv
// After its last request is taken, a result passes through the 2-stage multiply
// pipeline drain, 64 restoring divide steps and the output load.
// Throughput: one request per cycle within a vector; the bit-serial divider
// blocks input after each last request until that result is loaded for output, a
// load that waits while the previous result still waits on the output.
// Reset (arst_n low, asynchronous): accumulator 0, bias 0, modulus 1, no result pending.
module biased_dot_product_mod #(
	parameter int ELEMENT_WIDTH = bdpm_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [63:0]                          s_axis_tdata,  // lhs_elem, rhs_elem
	input  logic                                 s_axis_tuser,  // element_present
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [63:0]                          m_axis_tdata,  // remainder
	output logic                                 m_axis_tuser,  // error
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bdpm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bdpm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	bdpm_pkg::cmd_t    cmd;
	bdpm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bdpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	bdpm_datapath #(
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.lhs_elem        (s_axis_tdata[31:0]),
		.rhs_elem        (s_axis_tdata[63:32]),
		.element_present (s_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.remainder       (m_axis_tdata),
		.error           (m_axis_tuser)
	);

endmodule

>>> rtl/bdpm_checker.sv
module bdpm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [63:0]                          s_axis_tdata,
	input logic                                 s_axis_tuser,
	input logic                                 s_axis_tlast,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [63:0]                          m_axis_tdata,
	input logic                                 m_axis_tuser,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [bdpm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [bdpm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result with nonzero remainder");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken during remainder computation");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid && s_axis_tready)
		else $error("not idle after reset");

endmodule

bind biased_dot_product_mod bdpm_checker u_bdpm_checker (.*);

>>> verif/tb_biased_dot_product_mod.sv
`timescale 1ns / 100ps

module tb_biased_dot_product_mod;

	localparam int MW = bdpm_pkg::MOD_WIDTH;
	localparam int IW = bdpm_pkg::CFG_INDEX_WIDTH;
	localparam int DW = bdpm_pkg::CFG_DATA_WIDTH;
	localparam int LATENCY = 68;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam logic [MW-1:0] MOD_MAX = {MW{1'b1}};
	localparam logic [31:0] ELEM_MAX = 32'h7fff_ffff;
	localparam logic [31:0] ELEM_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
		logic        present;
		logic        last;
	} pair_t;

	typedef struct packed {
		logic [63:0] remainder;
		logic        error;
	} dot_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata = '0;   // lhs_elem, rhs_elem
	logic          s_axis_tuser = 1'b0; // element_present
	logic          s_axis_tlast = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [63:0]   m_axis_tdata;        // remainder
	logic          m_axis_tuser;        // error
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;

	logic [63:0]   acc_model = '0;
	logic [31:0]   bias_model = '0;
	logic [MW-1:0] modulus_model = MW'(1);

	dot_result_t pending_results[$];
	int          error_count = 0;
	int          pairs_sent = 0;
	int          remainders_checked = 0;
	int          reg_writes = 0;
	bit          src_idle_en = 1'b1;
	bit          sink_idle_en = 1'b1;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          sink_burst = 0;

	biased_dot_product_mod i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit mac_model_step(input pair_t p, output dot_result_t res);
		logic [63:0] lv, rv, bv, mag, rem;
		lv = {{32{p.left[31]}}, p.left};
		rv = {{32{p.right[31]}}, p.right};
		bv = {{32{bias_model[31]}}, bias_model};
		res = '0;
		if (p.present) begin
			acc_model = acc_model + (lv + bv) * rv;
		end
		if (!p.last) begin
			return 1'b0;
		end
		if (modulus_model == '0) begin
			res.error = 1'b1;
		end else begin
			mag = acc_model[63] ? -acc_model : acc_model;
			rem = mag % {1'b0, modulus_model};
			res.remainder = acc_model[63] ? -rem : rem;
		end
		acc_model = '0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] pick_element();
		case ($urandom_range(0, 9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2, 3: return 32'($urandom_range(0, 16) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MW-1:0] pick_modulus();
		case ($urandom_range(0, 4))
			0: return MW'($urandom_range(1, 1000));
			1: return MW'(1) << $urandom_range(0, MW - 1);
			2: return MW'($urandom);
			default: return MW'({$urandom, $urandom});
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("%0t: MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	task automatic send_pair(input pair_t p);
		dot_result_t res;
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.right, p.left};
		s_axis_tuser <= p.present;
		s_axis_tlast <= p.last;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pairs_sent++;
		if (mac_model_step(p, res)) begin
			pending_results.push_back(res);
		end
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		reg_writes++;
		if (idx == bdpm_pkg::REG_BIAS) begin
			bias_model = data[31:0];
		end else if (idx == bdpm_pkg::REG_MODULUS) begin
			modulus_model = data[MW-1:0];
		end
	endtask

	task automatic program_regs(input logic [31:0] b, input logic [MW-1:0] m,
			input bit junk);
		logic [IW-1:0] junk_idx;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		write_reg(bdpm_pkg::REG_BIAS, {$urandom, b});
		if (junk) begin
			junk_idx = IW'(bdpm_pkg::REG_MODULUS + 1 + $urandom_range(0, 253));
			write_reg(junk_idx, {$urandom, $urandom});
		end
		write_reg(bdpm_pkg::REG_MODULUS, {1'($urandom_range(0, 1)), m});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_vectors(input int n);
		int    sent;
		int    len;
		pair_t p;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(0, 19))
				0: len = 0;
				1, 2, 3: len = $urandom_range(9, 40);
				default: len = $urandom_range(1, 8);
			endcase
			if (len == 0) begin
				p = '{pick_element(), pick_element(), 1'b0, 1'b1};
				send_pair(p);
				sent++;
			end
			for (int i = 0; i < len; i++) begin
				p.left = pick_element();
				p.right = pick_element();
				p.present = ($urandom_range(0, 6) != 0);
				p.last = (i == len - 1);
				send_pair(p);
				if (p.present || p.last) begin
					sent++;
				end
			end
		end
	endtask

	task automatic test_directed();
		program_regs(32'd0, MOD_MAX, 1'b0);
		send_pair('{ELEM_MAX, ELEM_MAX, 1'b1, 1'b1});
		send_pair('{ELEM_MIN, ELEM_MIN, 1'b1, 1'b1});
		send_pair('{ELEM_MIN, ELEM_MAX, 1'b1, 1'b0});
		send_pair('{ELEM_MAX, ELEM_MIN, 1'b1, 1'b1});
		send_pair('{$urandom, $urandom, 1'b0, 1'b1});
		send_pair('{ELEM_MAX, ELEM_MIN, 1'b0, 1'b0});
		send_pair('{32'd3, 32'hffff_fffb, 1'b1, 1'b1});
		program_regs(ELEM_MIN, MW'(3), 1'b0);
		send_pair('{ELEM_MIN, ELEM_MIN, 1'b1, 1'b1});
		send_pair('{ELEM_MIN, ELEM_MIN, 1'b1, 1'b0});
		send_pair('{ELEM_MIN, ELEM_MIN, 1'b1, 1'b1});
		program_regs(ELEM_MIN, MOD_MAX, 1'b0);
		send_pair('{ELEM_MIN, ELEM_MIN, 1'b1, 1'b1});
		program_regs(ELEM_MAX, MW'(1), 1'b0);
		send_pair('{ELEM_MAX, ELEM_MAX, 1'b1, 1'b1});
		send_pair('{ELEM_MIN, 32'd7, 1'b1, 1'b1});
		program_regs(32'd5, '0, 1'b1);
		send_pair('{32'd5, 32'd7, 1'b1, 1'b1});
		send_pair('{32'd0, 32'd0, 1'b0, 1'b1});
		program_regs(32'hffff_fffe, MW'(1000), 1'b1);
		send_pair('{32'd9, 32'h8000_0001, 1'b1, 1'b0});
		send_pair('{ELEM_MAX, 32'd2, 1'b1, 1'b1});
	endtask

	task automatic test_random_settings();
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		program_regs($urandom, pick_modulus(), 1'b1);
		run_vectors(80);
		program_regs(ELEM_MAX, MOD_MAX, 1'b0);
		run_vectors(80);
		program_regs(ELEM_MIN, MW'($urandom_range(2, 9)), 1'b0);
		run_vectors(80);
		program_regs($urandom, '0, 1'b0);
		run_vectors(60);
		program_regs($urandom, MW'(1), 1'b0);
		run_vectors(60);
		src_idle_en = 1'b0;
		program_regs($urandom, pick_modulus(), 1'b1);
		run_vectors(80);
	endtask

	task automatic test_output_holdoff();
		src_idle_en = 1'b0;
		program_regs($urandom, pick_modulus(), 1'b0);
		hold_requests <= hold_requests + 1;
		run_vectors(40);
	endtask

	task automatic test_sender_pause();
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		run_vectors(20);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		run_vectors(20);
	endtask

	task automatic test_no_idle();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		program_regs($urandom, pick_modulus(), 1'b0);
		run_vectors(60);
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (sink_burst > 0 && sink_idle_en) begin
			sink_burst--;
			m_axis_tready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
			sink_burst = $urandom_range(1, 17) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dot_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				remainders_checked++;
				if (m_axis_tdata !== want.remainder) begin
					report_mismatch("remainder", m_axis_tdata, want.remainder);
				end
				if (m_axis_tuser !== want.error) begin
					report_mismatch("error flag", 64'(m_axis_tuser), 64'(want.error));
				end
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("%0t: timeout, no handshake for %0d cycles", $realtime, STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_output_holdoff();
		test_sender_pause();
		test_no_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d requests, checked %0d remainders, %0d register writes", pairs_sent,
			remainders_checked, reg_writes);
		$display("Covered extremes, zero modulus, empty vectors, wrap, stalls and idle gaps");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
